### src/vdrh_pkg.sv
// Shared types and constants for the v-disparity row histogram.
package vdrh_pkg;

    localparam int ROW_W   = 10;
    localparam int DISP_W  = 8;
    localparam int MAXD_W  = 9;
    localparam int COUNT_W = 8;
    localparam int BIN_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;
    localparam logic [ROW_W-1:0]   RST_START_ROW   = 10'd200;
    localparam logic [DISP_W-1:0]  RST_MIN_DISP    = 8'd6;
    localparam logic [MAXD_W-1:0]  RST_MAX_DISP    = 9'd253;
    localparam logic [COUNT_W-1:0] RST_NOISE_THR   = 8'd50;

    typedef enum logic
    {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_START_ROW = 2'd0,
        CFG_MIN_DISP  = 2'd1,
        CFG_MAX_DISP  = 2'd2,
        CFG_NOISE_THR = 2'd3
    } cfg_idx_t;

endpackage

### src/vdrh_bin_store.sv
// Histogram bin memory with per-bin valid bits and write-to-read forwarding.
module vdrh_bin_store
    import vdrh_pkg::*;
#(
    parameter int NUM_BINS = 256,
    parameter int ADDR_W   = $clog2(NUM_BINS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [COUNT_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [COUNT_W-1:0] wr_data
);

    logic [COUNT_W-1:0]  mem [NUM_BINS];
    logic [NUM_BINS-1:0] vld_reg;
    logic [COUNT_W-1:0]  mem_q_reg;
    logic                vld_q_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [COUNT_W-1:0]  fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            vld_q_reg   <= vld_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
            fwd_valid_reg    <= 1'b1;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
        begin
            rd_data = fwd_data_reg;
        end
        else if (vld_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

`ifndef ASSERT_OFF
    a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(wr_addr)])
        else $error("written bin not marked valid");

    a_fwd_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))
        else $error("read missed same-cycle write");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (rd_addr != wr_addr) && !vld_reg[rd_addr] |=> rd_data == '0)
        else $error("unwritten bin read nonzero");
`endif

endmodule

### src/v_disparity_row_histogram.sv
// One row of a v-disparity histogram: accumulate pixels, read and clear bins.
// Takes one item per clock whenever the result register is free or being
// drained: a pixel increments its disparity bin (saturating at 255) when its
// row is at or below start_row and its disparity lies strictly between the
// two limits; a read returns one bin (zero unless above noise_threshold) and
// clears it. Each item waits in the input stage while the bin memory is read,
// and a read result is then loaded into the output register when the pipe
// advances, which raises m_tvalid. The single read-modify-write path through
// the bin memory sets the rate of one item per cycle; a stalled output holds
// the input side. Bins come out of reset cleared through per-bin valid bits,
// with no clearing pass.
module v_disparity_row_histogram
    import vdrh_pkg::*;
#(
    parameter int NUM_BINS = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row[9:0], disparity[17:10], bin[25:18]
    input  logic                  s_tuser,   // opcode[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // count[7:0], read_bin[15:8]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam logic [MAXD_W-1:0] BINS_LIM = MAXD_W'(NUM_BINS);

    logic [ROW_W-1:0]   start_row_reg;
    logic [DISP_W-1:0]  min_disp_reg;
    logic [MAXD_W-1:0]  max_disp_reg;
    logic [COUNT_W-1:0] noise_thr_reg;

    logic [ROW_W-1:0]  in_row;
    logic [DISP_W-1:0] in_disp;
    logic [BIN_W-1:0]  in_bin;
    op_t               in_op;
    logic              counted;
    logic              bin_ok;
    logic              in_en;
    logic [ADDR_W-1:0] in_addr;
    logic              advance;

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic              s1_en_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [BIN_W-1:0]  s1_bin_reg;

    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;
    logic               wr_en;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [BIN_W-1:0]   m_bin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= RST_START_ROW;
            min_disp_reg  <= RST_MIN_DISP;
            max_disp_reg  <= RST_MAX_DISP;
            noise_thr_reg <= RST_NOISE_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_ROW: start_row_reg <= cfg_data[ROW_W-1:0];
                CFG_MIN_DISP:  min_disp_reg  <= cfg_data[DISP_W-1:0];
                CFG_MAX_DISP:  max_disp_reg  <= cfg_data[MAXD_W-1:0];
                CFG_NOISE_THR: noise_thr_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_row  = s_tdata[ROW_W-1:0];
    assign in_disp = s_tdata[ROW_W+DISP_W-1:ROW_W];
    assign in_bin  = s_tdata[ROW_W+DISP_W+BIN_W-1:ROW_W+DISP_W];
    assign in_op   = op_t'(s_tuser);

    assign counted = (in_row >= start_row_reg) && (in_disp > min_disp_reg)
                     && ({1'b0, in_disp} < max_disp_reg)
                     && ({1'b0, in_disp} < BINS_LIM);
    assign bin_ok  = ({1'b0, in_bin} < BINS_LIM);
    assign in_en   = (in_op == OP_READ) ? bin_ok : counted;
    assign in_addr = (in_op == OP_READ) ? in_bin[ADDR_W-1:0] : in_disp[ADDR_W-1:0];

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= in_op;
            s1_en_reg   <= in_en;
            s1_addr_reg <= in_addr;
            s1_bin_reg  <= in_bin;
        end
    end

    vdrh_bin_store #(
        .NUM_BINS (NUM_BINS),
        .ADDR_W   (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance),
        .rd_addr (in_addr),
        .rd_data (old_count),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (new_count)
    );

    assign wr_en = advance && s1_valid_reg && s1_en_reg;

    always_comb
    begin
        if (s1_op_reg == OP_READ)
        begin
            new_count = '0;
        end
        else if (old_count == COUNT_MAX)
        begin
            new_count = COUNT_MAX;
        end
        else
        begin
            new_count = old_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= s1_valid_reg && (s1_op_reg == OP_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_count_reg <= (s1_en_reg && (old_count > noise_thr_reg)) ? old_count : '0;
            m_bin_reg   <= s1_bin_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_bin_reg, m_count_reg};

`ifndef ASSERT_OFF
    a_accum_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && (s1_op_reg == OP_ACCUM) |=> !m_tvalid)
        else $error("accumulate produced a result");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ({1'b0, m_tdata[15:8]} >= BINS_LIM) |-> m_tdata[7:0] == '0)
        else $error("read beyond bins returned nonzero");

    a_count_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:0] != '0) |-> m_tdata[7:0] > noise_thr_reg)
        else $error("count not above noise threshold");
`endif

endmodule

### dv/v_disparity_row_histogram_test.sv
// Self-checking testbench for the v-disparity row histogram: streams pixels and bin reads.
module v_disparity_row_histogram_test
    import vdrh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_BINS = 256;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed
    {
        op_t               op;
        logic [ROW_W-1:0]  row;
        logic [DISP_W-1:0] disp;
        logic [BIN_W-1:0]  bin;
    } pix_item_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0] count;
        logic [BIN_W-1:0]   bin;
    } bin_read_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [ROW_W-1:0]   start_row_q = RST_START_ROW;
    logic [DISP_W-1:0]  min_disp_q = RST_MIN_DISP;
    logic [MAXD_W-1:0]  max_disp_q = RST_MAX_DISP;
    logic [COUNT_W-1:0] noise_q = RST_NOISE_THR;
    logic [COUNT_W-1:0] hist [HIST_BINS];

    pix_item_t   pixel_queue [$];
    bin_read_t   bin_reads_due [$];
    logic [7:0]  hot_bins [$];
    pix_item_t   offered;

    bit          idle_on = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_left = 0;
    int          long_hold_req = 0;
    int unsigned cycle_count = 0;
    int unsigned items_taken = 0;
    int unsigned reads_checked = 0;
    int unsigned reads_nonzero = 0;
    int unsigned reads_saturated = 0;
    int unsigned config_count = 0;
    int unsigned mismatch_count = 0;

    v_disparity_row_histogram #(.NUM_BINS(HIST_BINS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic histogram_update(input pix_item_t it);
        bin_read_t r;
        if (it.op == OP_ACCUM)
        begin
            if (it.row >= start_row_q && it.disp > min_disp_q && {1'b0, it.disp} < max_disp_q
                && int'(it.disp) < HIST_BINS && hist[it.disp] != COUNT_MAX)
                hist[it.disp] = hist[it.disp] + COUNT_W'(1);
        end
        else
        begin
            r.bin = it.bin;
            r.count = '0;
            if (int'(it.bin) < HIST_BINS)
            begin
                if (hist[it.bin] > noise_q)
                    r.count = hist[it.bin];
                hist[it.bin] = '0;
            end
            bin_reads_due = {bin_reads_due, r};
        end
    endtask

    // Driver: advance to the next pending item once the current one is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                histogram_update(offered);
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    offered = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, offered.bin, offered.disp, offered.row};
                    s_tuser <= offered.op;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 18);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each bin read against the oldest prediction, then pick m_tready.
    always @(posedge clk)
    begin
        bin_read_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (bin_reads_due.size() == 0)
                begin
                    $display("%0t: unexpected bin read: count %0d bin %0d",
                             $realtime, m_tdata[7:0], m_tdata[15:8]);
                    mismatch_count++;
                end
                else
                begin
                    want = bin_reads_due.pop_front();
                    reads_checked++;
                    if (want.count != 0)
                        reads_nonzero++;
                    if (want.count == COUNT_MAX)
                        reads_saturated++;
                    if (m_tdata[7:0] !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d (bin %0d)",
                                 $realtime, want.count, m_tdata[7:0], want.bin);
                        mismatch_count++;
                    end
                    if (m_tdata[15:8] !== want.bin)
                    begin
                        $display("%0t: read_bin expected %0d actual %0d",
                                 $realtime, want.bin, m_tdata[15:8]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req > 0)
            begin
                hold_left = long_hold_req - 1;
                long_hold_req = 0;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0)
                    sink_gap = $urandom_range(1, 18);
            end
        end
    end

    function automatic pix_item_t pix(op_t op, int r, int d, int b);
        pix_item_t it;
        it.op = op;
        it.row = ROW_W'(r);
        it.disp = DISP_W'(d);
        it.bin = BIN_W'(b);
        return it;
    endfunction

    function automatic pix_item_t make_item(int read_pct);
        pix_item_t it;
        it.op = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_ACCUM;
        if ($urandom_range(0, 3) != 0)
            it.row = ROW_W'($urandom_range(int'(start_row_q), 1023));
        else
            it.row = ROW_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) < 7)
            it.disp = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        else
            it.disp = DISP_W'($urandom_range(0, 255));
        if (it.op == OP_READ && $urandom_range(0, 9) < 7)
            it.bin = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        else
            it.bin = BIN_W'($urandom_range(0, 255));
        return it;
    endfunction

    // Concentrate pixels on a few bins inside the window so counts climb past the threshold.
    task automatic pick_hot_bins(int n);
        int lo;
        int hi;
        lo = int'(min_disp_q) + 1;
        hi = int'(max_disp_q) - 1;
        if (hi > 255)
            hi = 255;
        hot_bins.delete();
        repeat (n)
        begin
            if (lo <= hi)
                hot_bins = {hot_bins, DISP_W'($urandom_range(lo, hi))};
            else
                hot_bins = {hot_bins, DISP_W'($urandom_range(0, 255))};
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        case (idx)
            CFG_START_ROW: start_row_q = ROW_W'(value);
            CFG_MIN_DISP:  min_disp_q = DISP_W'(value);
            CFG_MAX_DISP:  max_disp_q = MAXD_W'(value);
            CFG_NOISE_THR: noise_q = COUNT_W'(value);
            default: ;
        endcase
    endtask

    task automatic set_config(int srow, int mind, int maxd, int noise);
        write_reg(CFG_START_ROW, srow);
        write_reg(CFG_MIN_DISP, mind);
        write_reg(CFG_MAX_DISP, maxd);
        write_reg(CFG_NOISE_THR, noise);
        @(posedge clk);
        cfg_we <= 1'b0;
        config_count++;
    endtask

    task automatic random_config();
        int mind;
        int maxd;
        mind = $urandom_range(0, 60);
        maxd = mind + $urandom_range(30, 200);
        if (maxd > 256)
            maxd = 256;
        set_config($urandom_range(0, 600), mind, maxd, $urandom_range(0, 12));
        pick_hot_bins(8);
    endtask

    // Wait until every item is taken and every read has come back, then let the pipe settle.
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || s_tvalid || bin_reads_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(int n, int read_pct);
        @(negedge clk);
        repeat (n) pixel_queue = {pixel_queue, make_item(read_pct)};
        drain();
    endtask

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("%0t: run timed out with %0d reads outstanding",
                 $realtime, bin_reads_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int mind;
        foreach (hist[i])
            hist[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Window edges, rows above the start, unused fields set, reads of empty and edge bins.
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 1023, 255, 255)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 0, 100, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 199, 100, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 200, 100, 255)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 200, 6, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 200, 7, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 200, 253, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 1023, 252, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 1023, 0, 0)};
        pixel_queue = {pixel_queue, pix(OP_READ, 1023, 255, 100)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 100)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 0)};
        pixel_queue = {pixel_queue, pix(OP_READ, 1023, 255, 255)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 7)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 252)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 253)};
        drain();

        // Widest window, no threshold: drive the top bin into saturation.
        set_config(0, 0, 256, 0);
        @(negedge clk);
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 0, 0, 0)};
        pixel_queue = {pixel_queue, pix(OP_ACCUM, 1023, 1, 0)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 0)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 1)};
        repeat (258)
            pixel_queue = {pixel_queue, pix(OP_ACCUM, $urandom_range(0, 1023), 255, 0)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 255)};
        pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, 255)};
        drain();

        // Hold the output off early so the block fills and stalls its input.
        random_config();
        @(negedge clk);
        long_hold_req = 300;
        repeat (4)
            pixel_queue = {pixel_queue, pix(OP_READ, 0, 0, $urandom_range(0, 255))};
        run_random(300, 8);

        set_config(1023, 255, 0, 255);
        pick_hot_bins(8);
        run_random(100, 20);

        mind = $urandom_range(0, 254);
        set_config($urandom_range(0, 1023), mind, mind + 1, 0);
        pick_hot_bins(8);
        run_random(80, 20);

        mind = $urandom_range(0, 253);
        set_config($urandom_range(0, 400), mind, mind + 2, $urandom_range(0, 5));
        pick_hot_bins(1);
        run_random(120, 8);

        random_config();
        run_random(300, 8);

        idle_on = 1'b0;
        random_config();
        run_random(200, 8);

        $display("Covered %0d items over %0d register settings, %0d bin reads checked",
                 items_taken, config_count + 1, reads_checked);
        $display("Reads above threshold: %0d, saturated reads: %0d, mismatches: %0d",
                 reads_nonzero, reads_saturated, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
src/vdrh_pkg.sv
src/vdrh_bin_store.sv
src/v_disparity_row_histogram.sv
dv/v_disparity_row_histogram_test.sv
